// ----- hw/rtl/matrix_key_scan_debounce_repeat_assert.svh -----
// Assertion macros for the keypad scanner.
`ifndef MATRIX_KEY_SCAN_DEBOUNCE_REPEAT_ASSERT_SVH
`define MATRIX_KEY_SCAN_DEBOUNCE_REPEAT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MKSDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MKSDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mksdr_pkg.sv -----
// Shared types and constants for the keypad scanner.
package mksdr_pkg;

    localparam int CODE_W     = 24;
    localparam int HOLD_W     = 10;
    localparam int GAP_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ROW_LG     = 3;

    localparam int ROWS_DEF = 3;
    localparam int COLS_DEF = 5;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 10'd1023;

    localparam logic [HOLD_W-1:0] DEBOUNCE_RST    = 10'd3;
    localparam logic [HOLD_W-1:0] HOLD_FAST_RST   = 10'd100;
    localparam logic [HOLD_W-1:0] HOLD_SLOW_RST   = 10'd300;
    localparam logic [HOLD_W-1:0] BACK_OFF_RST    = 10'd50;
    localparam logic [GAP_W-1:0]  SEND_GAP_RST    = 6'd50;
    localparam logic [CODE_W-1:0] FAST_KEY_RST    = 24'h020000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_HOLD_FAST = 3'd1,
        CFG_HOLD_SLOW = 3'd2,
        CFG_BACK_OFF  = 3'd3,
        CFG_SEND_GAP  = 3'd4,
        CFG_FAST_KEY  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [HOLD_W-1:0] debounce_count;
        logic [HOLD_W-1:0] repeat_hold_fast;
        logic [HOLD_W-1:0] repeat_hold_slow;
        logic [HOLD_W-1:0] repeat_back_off;
        logic [GAP_W-1:0]  send_gap;
        logic [CODE_W-1:0] fast_repeat_key;
    } t_cfg;

    typedef struct packed {
        logic              event_valid;
        logic [CODE_W-1:0] key_code;
        logic              repeat_flag;
    } t_event;

endpackage

// ----- hw/rtl/matrix_key_scan_debounce_repeat.sv -----
// Top level of the keypad matrix scanner with debounce and auto-repeat.
//
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_stall     i_column_levels
//  out      source     o_out_valid / i_out_stall   o_row_select, o_event_valid,
//                                                  o_key_code, o_repeat_flag
//  cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item per clock while the output is not stalled; each item gives one result.
// An item passes the input register, a single scan state update and the result
// register, in that order.
// Reset is synchronous, active low; valid flags reset, payload registers do not.
// A stalled result holds in the output register while one more item waits.
// The cfg channel is always ready.
module matrix_key_scan_debounce_repeat #(
    parameter int ROWS  = mksdr_pkg::ROWS_DEF,
    parameter int COLS  = mksdr_pkg::COLS_DEF,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [COLS-1:0]                   i_column_levels,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ROW_W-1:0]                  o_row_select,
    output logic                              o_event_valid,
    output logic [mksdr_pkg::CODE_W-1:0]      o_key_code,
    output logic                              o_repeat_flag,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mksdr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mksdr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    mksdr_pkg::t_cfg   cfg;
    mksdr_pkg::t_event core_event;
    logic [ROW_W-1:0]  core_row;

    logic              r_s1_valid;
    logic [COLS-1:0]   r_s1_cols;
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    mksdr_pkg::t_event r_out_event;

    logic s1_adv;
    logic in_acc;

    assign o_cfg_ready = 1'b1;

    mksdr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign s1_adv     = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~s1_adv;
    assign in_acc     = i_in_valid & ~o_in_stall;

    mksdr_scan_core #(
        .ROWS  (ROWS),
        .COLS  (COLS),
        .ROW_W (ROW_W)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_adv),
        .i_cols       (r_s1_cols),
        .i_cfg        (cfg),
        .o_row_select (core_row),
        .o_event      (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cols <= i_column_levels;
        end
        if (s1_adv) begin
            r_out_row   <= core_row;
            r_out_event <= core_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_select  = r_out_row;
    assign o_event_valid = r_out_event.event_valid;
    assign o_key_code    = r_out_event.key_code;
    assign o_repeat_flag = r_out_event.repeat_flag;

`include "matrix_key_scan_debounce_repeat_assert.svh"

    `MKSDR_ASSERT_NOW(a_event_on_frame_end, r_out_valid && r_out_event.event_valid,
        r_out_row == '0, "event outside the last row of a frame")
    `MKSDR_ASSERT_NOW(a_repeat_has_code, r_out_valid && r_out_event.repeat_flag,
        r_out_event.event_valid && r_out_event.key_code != '0, "repeat without a key code")
    `MKSDR_ASSERT_NEXT(a_item_kept, r_s1_valid && r_out_valid && i_out_stall,
        r_s1_valid && $stable(r_s1_cols), "waiting item lost under stall")

endmodule

// ----- hw/rtl/mksdr_cfg_regs.sv -----
// Configuration register file for the keypad scanner.
module mksdr_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [mksdr_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [mksdr_pkg::CFG_DATA_W-1:0]    i_data,
    output mksdr_pkg::t_cfg                     o_cfg
);

    mksdr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_count   <= mksdr_pkg::DEBOUNCE_RST;
            r_cfg.repeat_hold_fast <= mksdr_pkg::HOLD_FAST_RST;
            r_cfg.repeat_hold_slow <= mksdr_pkg::HOLD_SLOW_RST;
            r_cfg.repeat_back_off  <= mksdr_pkg::BACK_OFF_RST;
            r_cfg.send_gap         <= mksdr_pkg::SEND_GAP_RST;
            r_cfg.fast_repeat_key  <= mksdr_pkg::FAST_KEY_RST;
        end else if (i_wr) begin
            unique case (mksdr_pkg::t_cfg_idx'(i_index))
                mksdr_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_count <= i_data[mksdr_pkg::HOLD_W-1:0];
                end
                mksdr_pkg::CFG_HOLD_FAST: begin
                    r_cfg.repeat_hold_fast <= i_data[mksdr_pkg::HOLD_W-1:0];
                end
                mksdr_pkg::CFG_HOLD_SLOW: begin
                    r_cfg.repeat_hold_slow <= i_data[mksdr_pkg::HOLD_W-1:0];
                end
                mksdr_pkg::CFG_BACK_OFF: begin
                    r_cfg.repeat_back_off <= i_data[mksdr_pkg::HOLD_W-1:0];
                end
                mksdr_pkg::CFG_SEND_GAP: begin
                    r_cfg.send_gap <= i_data[mksdr_pkg::GAP_W-1:0];
                end
                mksdr_pkg::CFG_FAST_KEY: begin
                    r_cfg.fast_repeat_key <= i_data[mksdr_pkg::CODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/mksdr_scan_core.sv -----
// Scan state, debounce, auto-repeat and rate limit for one tick per step.
module mksdr_scan_core #(
    parameter int ROWS  = mksdr_pkg::ROWS_DEF,
    parameter int COLS  = mksdr_pkg::COLS_DEF,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [COLS-1:0]  i_cols,
    input  mksdr_pkg::t_cfg  i_cfg,
    output logic [ROW_W-1:0] o_row_select,
    output mksdr_pkg::t_event o_event
);

    localparam int CODE_W = mksdr_pkg::CODE_W;
    localparam int HOLD_W = mksdr_pkg::HOLD_W;
    localparam int GAP_W  = mksdr_pkg::GAP_W;
    localparam int WIDE_W = COLS + (ROWS - 1) * (1 << mksdr_pkg::ROW_LG) + CODE_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [ROW_W-1:0]  r_scan_row, n_scan_row;
    logic [CODE_W-1:0] r_latched, n_latched;
    logic [CODE_W-1:0] r_stable, n_stable;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [GAP_W-1:0]  r_gap, n_gap;
    logic [CODE_W-1:0] r_current, n_current;

    logic [COLS-1:0]   pressed;
    logic [WIDE_W-1:0] wide;
    logic [CODE_W-1:0] shifted;
    logic [HOLD_W-1:0] hold_inc;
    logic [HOLD_W-1:0] thr;
    logic              gap_ok;
    mksdr_pkg::t_event n_event;

    assign pressed = ~i_cols;
    assign wide    = WIDE_W'(pressed) << {r_scan_row, {mksdr_pkg::ROW_LG{1'b0}}};
    assign shifted = wide[CODE_W-1:0];

    always_comb begin
        n_latched = (r_scan_row == '0) ? '0 : r_latched;
        if (n_latched == '0 && pressed != '0) begin
            n_latched = shifted;
        end

        n_gap = (r_gap < i_cfg.send_gap) ? r_gap + 1'b1 : r_gap;
        gap_ok = (n_gap >= i_cfg.send_gap);

        n_stable  = r_stable;
        n_hold    = r_hold;
        n_current = r_current;
        n_event   = '0;
        hold_inc  = (r_hold < mksdr_pkg::HOLD_MAX) ? r_hold + 1'b1 : r_hold;
        thr = (r_stable == i_cfg.fast_repeat_key) ? i_cfg.repeat_hold_fast
                                                  : i_cfg.repeat_hold_slow;

        if (r_scan_row == LAST_ROW) begin
            if (n_latched == '0) begin
                n_event.event_valid = (r_current != '0);
                n_current = '0;
                n_stable  = '0;
                n_hold    = '0;
            end else if (r_stable == n_latched) begin
                n_hold = hold_inc;
                if (i_cfg.debounce_count != '0 && hold_inc == i_cfg.debounce_count) begin
                    n_current = n_latched;
                    if (gap_ok) begin
                        n_event.event_valid = 1'b1;
                        n_event.key_code    = n_latched;
                        n_gap               = '0;
                    end
                end
                if (thr != '0 && hold_inc == thr) begin
                    n_current = n_latched;
                    n_hold = (hold_inc > i_cfg.repeat_back_off)
                           ? hold_inc - i_cfg.repeat_back_off : '0;
                    if (!n_event.event_valid && gap_ok) begin
                        n_event.event_valid = 1'b1;
                        n_event.key_code    = n_latched;
                        n_event.repeat_flag = 1'b1;
                        n_gap               = '0;
                    end
                end
            end else begin
                n_hold   = '0;
                n_stable = n_latched;
            end
        end

        n_scan_row = (r_scan_row == LAST_ROW) ? '0 : r_scan_row + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
            r_latched  <= '0;
            r_stable   <= '0;
            r_hold     <= '0;
            r_gap      <= '0;
            r_current  <= '0;
        end else if (i_step) begin
            r_scan_row <= n_scan_row;
            r_latched  <= n_latched;
            r_stable   <= n_stable;
            r_hold     <= n_hold;
            r_gap      <= n_gap;
            r_current  <= n_current;
        end
    end

    assign o_row_select = n_scan_row;
    assign o_event      = n_event;

endmodule
